FILE: rtl/core/suvm_pkg.sv
// ----------------------------------------------------------------------------
// suvm_pkg
// Shared types, constants and helpers for the spherical UV mapping pipeline.
// ----------------------------------------------------------------------------
package suvm_pkg;

   // Operands are normalized so the largest lies in [2^29, 2^30)
   localparam int NORM_W  = 30;
   // Squares and their sum for the radius
   localparam int SQ_W    = 2 * NORM_W;
   localparam int SUM_W   = SQ_W + 1;
   localparam int ROOT_W  = (SUM_W + 1) / 2;
   // CORDIC datapath and angle accumulator (signed)
   localparam int CORDIC_W = 34;
   localparam int ACC_W    = 34;
   // Turn values in Q0.32 plus one bit for a full turn
   localparam int TURN_W   = 33;
   localparam logic [TURN_W-1:0] QUARTER_TURN = 33'h0_4000_0000;
   localparam logic [TURN_W-1:0] THREE_QUARTER_TURN = 33'h0_C000_0000;
   localparam logic [TURN_W-1:0] FULL_TURN = 33'h1_0000_0000;
   // Arctangent table in Q0.32 turns
   localparam int ATAN_LEN = 24;
   localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   localparam int LEN_W = 7;

   // Per-vertex flags that travel with the item
   typedef struct packed {
      logic x0;
      logic y0;
      logic z0;
      logic nx;
      logic ny;
      logic nz;
   } suvm_flags_type;

   // Position of the highest set bit plus one, zero for zero
   function automatic logic [LEN_W-1:0] bit_len(input logic [63:0] v);
      logic [LEN_W-1:0] n;
      n = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            n = LEN_W'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

FILE: rtl/core/suvm_isqrt.sv
// ----------------------------------------------------------------------------
// suvm_isqrt
// Pipelined floor square root, one result bit resolved per stage.
// ----------------------------------------------------------------------------
module suvm_isqrt
   import suvm_pkg::*;
#(
   parameter int IN_W = 61
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [IN_W-1:0]           radicand,
   output logic [(IN_W+1)/2-1:0]     root
);

   localparam int RW = (IN_W + 1) / 2;
   localparam int TW = 2 * RW + 1;

   logic [TW-1:0] rem_ff [RW];
   logic [RW-1:0] res_ff [RW];

   genvar j;
   for (j = 0; j < RW; j++) begin : g_bit
      localparam int BI = RW - 1 - j;
      logic [TW-1:0] rem_cur;
      logic [TW-1:0] trial;
      logic [TW-1:0] rem_in;
      logic [RW-1:0] res_cur;
      logic [RW-1:0] res_in;

      if (j == 0) begin : g_first
         assign rem_cur = TW'(radicand);
         assign res_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[j-1];
         assign res_cur = res_ff[j-1];
      end

      // (res + b)^2 - res^2 = res*2b + b^2, with b = 2^BI
      always_comb begin
         trial = (TW'(res_cur) << (BI + 1)) + (TW'(1) << (2 * BI));
         if (rem_cur >= trial) begin
            rem_in = rem_cur - trial;
            res_in = res_cur | (RW'(1) << BI);
         end else begin
            rem_in = rem_cur;
            res_in = res_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            res_ff[j] <= res_in;
         end
      end
   end

   assign root = res_ff[RW-1];

endmodule

FILE: rtl/core/suvm_cordic.sv
// ----------------------------------------------------------------------------
// suvm_cordic
// Pipelined CORDIC vectoring: atan(num/den) in Q0.32 turns, one stage per step.
// ----------------------------------------------------------------------------
module suvm_cordic
   import suvm_pkg::*;
#(
   parameter int ITERS = 16
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [NORM_W-1:0]          den,
   input  logic [NORM_W-1:0]          num,
   output logic signed [ACC_W-1:0]    angle
);

   localparam int NC = (ITERS < ATAN_LEN) ? ITERS : ATAN_LEN;

   logic signed [CORDIC_W-1:0] cx_ff  [NC];
   logic signed [CORDIC_W-1:0] cy_ff  [NC];
   logic signed [ACC_W-1:0]    acc_ff [NC];

   genvar k;
   for (k = 0; k < NC; k++) begin : g_iter
      logic signed [CORDIC_W-1:0] cx_cur, cy_cur, cx_in, cy_in, dx, dy;
      logic signed [ACC_W-1:0]    acc_cur, acc_in, step;

      if (k == 0) begin : g_first
         assign cx_cur  = $signed(CORDIC_W'(den));
         assign cy_cur  = $signed(CORDIC_W'(num));
         assign acc_cur = '0;
      end else begin : g_next
         assign cx_cur  = cx_ff[k-1];
         assign cy_cur  = cy_ff[k-1];
         assign acc_cur = acc_ff[k-1];
      end

      // rotate toward the x axis; shifts round toward minus infinity
      always_comb begin
         dx   = cy_cur >>> k;
         dy   = cx_cur >>> k;
         step = $signed(ACC_W'(ATAN_TURNS[k]));
         if (cy_cur >= 0) begin
            cx_in  = cx_cur + dx;
            cy_in  = cy_cur - dy;
            acc_in = acc_cur + step;
         end else begin
            cx_in  = cx_cur - dx;
            cy_in  = cy_cur + dy;
            acc_in = acc_cur - step;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[k]  <= cx_in;
            cy_ff[k]  <= cy_in;
            acc_ff[k] <= acc_in;
         end
      end
   end

   assign angle = acc_ff[NC-1];

endmodule

FILE: rtl/core/spherical_uv_mapping.sv
// ----------------------------------------------------------------------------
// spherical_uv_mapping
// Vertex (x, y, z) to spherical texture coordinates (s, t) in turns.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one vertex per transfer (signed Q16.16 x, y, z).
//   rsp_ channel returns one result per vertex, in order: s_coord, t_coord
//   (unsigned Q0.UV_WIDTH turns) and the two undefined flags.
//   The pipeline has five front stages (magnitude, bit length, normalize,
//   square, sum), 31 square-root stages, two renormalize stages, one stage
//   per CORDIC step and one output stage.
//   Throughput is one vertex per cycle while the output is not stalled; both
//   CORDIC pipelines and the square-root pipeline take a new item whenever the pipeline advances.
//   Reset clears all valid bits; the pipeline is empty afterwards.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and req_ready drops; a bubble at the output lets the pipe advance.
// ----------------------------------------------------------------------------
module spherical_uv_mapping
   import suvm_pkg::*;
#(
   parameter int COORD_WIDTH  = 32,
   parameter int UV_WIDTH     = 16,
   parameter int ANGLE_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_y,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [UV_WIDTH-1:0]           rsp_s_coord,
   output logic [UV_WIDTH-1:0]           rsp_t_coord,
   output logic                          rsp_s_undefined,
   output logic                          rsp_t_undefined
);

   localparam int W   = COORD_WIDTH;
   localparam int NC  = (ANGLE_STAGES < ATAN_LEN) ? ANGLE_STAGES : ATAN_LEN;
   localparam int LAT = 5 + ROOT_W + 2 + NC + 1;
   localparam int SH  = 32 - UV_WIDTH;
   localparam logic [TURN_W:0] UV_MAX = (TURN_W+1)'((64'd1 << UV_WIDTH) - 64'd1);

   logic adv;
   logic [LAT-1:0] vld_ff;

   // pipeline advances whenever the output slot is empty or being taken
   assign adv       = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // stage 1: magnitudes and flags
   logic [W-1:0] mx1_ff, my1_ff, mz1_ff;
   logic [W-1:0] mx1_in, my1_in, mz1_in;
   suvm_flags_type fl1_ff, fl1_in;

   always_comb begin
      mx1_in = req_vertex_x[W-1] ? W'(-req_vertex_x) : W'(req_vertex_x);
      my1_in = req_vertex_y[W-1] ? W'(-req_vertex_y) : W'(req_vertex_y);
      mz1_in = req_vertex_z[W-1] ? W'(-req_vertex_z) : W'(req_vertex_z);
      fl1_in.x0 = (req_vertex_x == '0);
      fl1_in.y0 = (req_vertex_y == '0);
      fl1_in.z0 = (req_vertex_z == '0);
      fl1_in.nx = req_vertex_x[W-1];
      fl1_in.ny = req_vertex_y[W-1];
      fl1_in.nz = req_vertex_z[W-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mx1_ff <= mx1_in;
         my1_ff <= my1_in;
         mz1_ff <= mz1_in;
         fl1_ff <= fl1_in;
      end
   end

   // stage 2: bit lengths of the pair max and the triple max
   logic [W-1:0] mx2_ff, my2_ff, mz2_ff;
   logic [LEN_W-1:0] ls2_ff, lt2_ff, ls2_in, lt2_in;
   logic [W-1:0] mxs, mxt;
   suvm_flags_type fl2_ff;

   always_comb begin
      mxs    = (mx1_ff > my1_ff) ? mx1_ff : my1_ff;
      mxt    = (mxs > mz1_ff) ? mxs : mz1_ff;
      ls2_in = bit_len(64'(mxs));
      lt2_in = bit_len(64'(mxt));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mx2_ff <= mx1_ff;
         my2_ff <= my1_ff;
         mz2_ff <= mz1_ff;
         ls2_ff <= ls2_in;
         lt2_ff <= lt2_in;
         fl2_ff <= fl1_ff;
      end
   end

   // stage 3: scale by 2^(30 - len)
   logic [W+NORM_W-1:0] wsx, wsy, wtx, wty, wtz;
   logic [NORM_W-1:0] sx3_ff, sy3_ff, tx3_ff, ty3_ff, tz3_ff;
   suvm_flags_type fl3_ff;

   always_comb begin
      wsx = {mx2_ff, NORM_W'(0)} >> ls2_ff;
      wsy = {my2_ff, NORM_W'(0)} >> ls2_ff;
      wtx = {mx2_ff, NORM_W'(0)} >> lt2_ff;
      wty = {my2_ff, NORM_W'(0)} >> lt2_ff;
      wtz = {mz2_ff, NORM_W'(0)} >> lt2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx3_ff <= wsx[NORM_W-1:0];
         sy3_ff <= wsy[NORM_W-1:0];
         tx3_ff <= wtx[NORM_W-1:0];
         ty3_ff <= wty[NORM_W-1:0];
         tz3_ff <= wtz[NORM_W-1:0];
         fl3_ff <= fl2_ff;
      end
   end

   // stage 4: squares
   logic [SQ_W-1:0] sqx4_ff, sqy4_ff;
   logic [NORM_W-1:0] sx4_ff, sy4_ff, tz4_ff;
   suvm_flags_type fl4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx4_ff <= SQ_W'(tx3_ff) * SQ_W'(tx3_ff);
         sqy4_ff <= SQ_W'(ty3_ff) * SQ_W'(ty3_ff);
         sx4_ff  <= sx3_ff;
         sy4_ff  <= sy3_ff;
         tz4_ff  <= tz3_ff;
         fl4_ff  <= fl3_ff;
      end
   end

   // stage 5: sum of squares
   logic [SUM_W-1:0] sum5_ff;
   logic [NORM_W-1:0] sx5_ff, sy5_ff, tz5_ff;
   suvm_flags_type fl5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sum5_ff <= SUM_W'(sqx4_ff) + SUM_W'(sqy4_ff);
         sx5_ff  <= sx4_ff;
         sy5_ff  <= sy4_ff;
         tz5_ff  <= tz4_ff;
         fl5_ff  <= fl4_ff;
      end
   end

   // radius square root, with side data delayed alongside
   logic [ROOT_W-1:0] root;
   logic [NORM_W-1:0] sxq_ff [ROOT_W];
   logic [NORM_W-1:0] syq_ff [ROOT_W];
   logic [NORM_W-1:0] tzq_ff [ROOT_W];
   suvm_flags_type    flq_ff [ROOT_W];

   suvm_isqrt #(
      .IN_W (SUM_W)
   ) u_isqrt (
      .clock    (clock),
      .en       (adv),
      .radicand (sum5_ff),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sxq_ff[0] <= sx5_ff;
         syq_ff[0] <= sy5_ff;
         tzq_ff[0] <= tz5_ff;
         flq_ff[0] <= fl5_ff;
         for (int i = 1; i < ROOT_W; i++) begin
            sxq_ff[i] <= sxq_ff[i-1];
            syq_ff[i] <= syq_ff[i-1];
            tzq_ff[i] <= tzq_ff[i-1];
            flq_ff[i] <= flq_ff[i-1];
         end
      end
   end

   // renormalize stage 1: bit length of max(r, z')
   logic [ROOT_W-1:0] rn1_ff, mxr;
   logic [NORM_W-1:0] tzn1_ff, sxn1_ff, syn1_ff;
   logic [LEN_W-1:0] lr1_ff;
   suvm_flags_type fln1_ff;

   assign mxr = (root > ROOT_W'(tzq_ff[ROOT_W-1])) ? root : ROOT_W'(tzq_ff[ROOT_W-1]);

   always_ff @(posedge clock) begin
      if (adv) begin
         rn1_ff  <= root;
         tzn1_ff <= tzq_ff[ROOT_W-1];
         lr1_ff  <= bit_len(64'(mxr));
         sxn1_ff <= sxq_ff[ROOT_W-1];
         syn1_ff <= syq_ff[ROOT_W-1];
         fln1_ff <= flq_ff[ROOT_W-1];
      end
   end

   // renormalize stage 2: scale r and z' together
   logic [ROOT_W+NORM_W-1:0] wr, wz;
   logic [NORM_W-1:0] rn2_ff, zn2_ff, sxn2_ff, syn2_ff;
   suvm_flags_type fln2_ff;

   always_comb begin
      wr = {rn1_ff, NORM_W'(0)} >> lr1_ff;
      wz = {ROOT_W'(tzn1_ff), NORM_W'(0)} >> lr1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rn2_ff  <= wr[NORM_W-1:0];
         zn2_ff  <= wz[NORM_W-1:0];
         sxn2_ff <= sxn1_ff;
         syn2_ff <= syn1_ff;
         fln2_ff <= fln1_ff;
      end
   end

   // angle units for s and t
   logic signed [ACC_W-1:0] ang_s, ang_t;
   suvm_flags_type flc_ff [NC];

   suvm_cordic #(
      .ITERS (ANGLE_STAGES)
   ) u_cordic_s (
      .clock (clock),
      .en    (adv),
      .den   (sxn2_ff),
      .num   (syn2_ff),
      .angle (ang_s)
   );

   suvm_cordic #(
      .ITERS (ANGLE_STAGES)
   ) u_cordic_t (
      .clock (clock),
      .en    (adv),
      .den   (zn2_ff),
      .num   (rn2_ff),
      .angle (ang_t)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         flc_ff[0] <= fln2_ff;
         for (int i = 1; i < NC; i++) begin
            flc_ff[i] <= flc_ff[i-1];
         end
      end
   end

   // output stage: clamp, quadrant fix-up, special cases, round and saturate
   suvm_flags_type fo;
   logic [TURN_W-1:0] qs, qt, s_turn, t_turn;
   logic [TURN_W:0] s_rnd, t_rnd, s_sh, t_sh;
   logic [UV_WIDTH-1:0] s_coord_in, t_coord_in;
   logic s_und_in, t_und_in;

   always_comb begin
      fo = flc_ff[NC-1];

      if (ang_s < 0) begin
         qs = '0;
      end else if (ang_s > $signed(ACC_W'(QUARTER_TURN))) begin
         qs = QUARTER_TURN;
      end else begin
         qs = TURN_W'(ang_s);
      end
      if (ang_t < 0) begin
         qt = '0;
      end else if (ang_t > $signed(ACC_W'(QUARTER_TURN))) begin
         qt = QUARTER_TURN;
      end else begin
         qt = TURN_W'(ang_t);
      end

      s_und_in = fo.x0 && fo.y0;
      t_und_in = fo.x0 && fo.y0 && fo.z0;

      // azimuth
      if (s_und_in) begin
         s_turn = '0;
      end else if (fo.x0) begin
         s_turn = fo.ny ? THREE_QUARTER_TURN : QUARTER_TURN;
      end else if (fo.y0) begin
         s_turn = '0;
      end else if ((fo.nx != fo.ny) && (qs != '0)) begin
         s_turn = FULL_TURN - qs;
      end else begin
         s_turn = qs;
      end

      // polar angle
      if (t_und_in) begin
         t_turn = '0;
      end else if (fo.z0) begin
         t_turn = QUARTER_TURN;
      end else if (!(fo.x0 && fo.y0)) begin
         t_turn = (fo.nz && (qt != '0)) ? FULL_TURN - qt : qt;
      end else begin
         t_turn = '0;
      end

      // round half up, saturate at full scale
      s_rnd = (TURN_W+1)'(s_turn) + ((TURN_W+1)'(1) << (SH - 1));
      t_rnd = (TURN_W+1)'(t_turn) + ((TURN_W+1)'(1) << (SH - 1));
      s_sh  = s_rnd >> SH;
      t_sh  = t_rnd >> SH;
      s_coord_in = (s_sh > UV_MAX) ? '1 : s_sh[UV_WIDTH-1:0];
      t_coord_in = (t_sh > UV_MAX) ? '1 : t_sh[UV_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_s_coord     <= s_coord_in;
         rsp_t_coord     <= t_coord_in;
         rsp_s_undefined <= s_und_in;
         rsp_t_undefined <= t_und_in;
      end
   end

endmodule

FILE: rtl/core/suvm_checker.sv
// ----------------------------------------------------------------------------
// suvm_checker
// Port-level checks for spherical_uv_mapping, bound to the top level.
// ----------------------------------------------------------------------------
module suvm_checker #(
   parameter int UV_WIDTH = 16
) (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [UV_WIDTH-1:0] rsp_s_coord,
   input logic [UV_WIDTH-1:0] rsp_t_coord,
   input logic                rsp_s_undefined,
   input logic                rsp_t_undefined
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its s and t coordinates
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_s_coord) && $stable(rsp_t_coord))
      else $error("result changed while stalled");

   // an empty output slot never blocks the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // undefined azimuth reads as zero
   a_s_undef: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_s_undefined |-> rsp_s_coord == '0)
      else $error("s_coord nonzero when undefined");

   // undefined polar angle implies undefined azimuth and zero t
   a_t_undef: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_t_undefined |-> rsp_s_undefined && (rsp_t_coord == '0))
      else $error("t_undefined inconsistent");

endmodule

bind spherical_uv_mapping suvm_checker #(
   .UV_WIDTH (UV_WIDTH)
) u_suvm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_s_coord     (rsp_s_coord),
   .rsp_t_coord     (rsp_t_coord),
   .rsp_s_undefined (rsp_s_undefined),
   .rsp_t_undefined (rsp_t_undefined)
);
